[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion with a reset that disables it.
`define SMASK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion that is checked through reset as well.
`define SMASK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[design/smask_pkg.sv]
// ----------------------------------------------------------------------------
// smask_pkg
// Shared constants and types of the stream pattern mask block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smask_pkg;

   localparam int PATTERN_MAX = 8;
   // window never holds a full pattern between requests
   localparam int CNT_W       = 3;
   // lengths and result counts, 0..PATTERN_MAX
   localparam int LEN_W       = 4;
   localparam int IDX_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [7:0] MASK_CHAR = 8'h2A;

   typedef enum logic {
      REG_PATTERN_LENGTH = 1'b0,
      REG_PATTERN_BYTES  = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // one queued request: the results it causes, in order
   typedef struct packed {
      logic [PATTERN_MAX-1:0][7:0] bytes;
      logic [LEN_W-1:0]            count;
      logic                        is_end;
      logic                        empty;
   } smask_entry_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } smask_qstat_type;

endpackage

[design/smask_front.sv]
// ----------------------------------------------------------------------------
// smask_front
// Accepts requests, tracks the match window and builds one queue entry
// holding all results of a request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smask_front import smask_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_kind,
   input  logic [7:0]      req_data_byte,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic            csr_index,
   input  logic [63:0]     csr_wdata,
   input  smask_qstat_type q_stat,
   output logic            push,
   output smask_entry_type push_entry
);

   logic [LEN_W-1:0] pat_len_ff;
   logic [63:0]      pat_bytes_ff;
   logic [7:0]       win_ff [PATTERN_MAX];
   logic [7:0]       win_in [PATTERN_MAX];
   logic [CNT_W-1:0] win_cnt_ff;
   logic [CNT_W-1:0] win_cnt_in;

   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] total;
   logic [7:0]       ext [PATTERN_MAX];
   logic [LEN_W-1:0] rem_k [PATTERN_MAX+1];
   logic             viable [PATTERN_MAX+1];
   logic [LEN_W-1:0] kpop;
   logic             masked;
   logic             accept;
   smask_entry_type  data_entry;
   smask_entry_type  end_entry;

   assign csr_ready = 1'b1;
   assign req_ready = q_stat.not_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      eff_len = (pat_len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_ff;
      total   = {1'b0, win_cnt_ff} + LEN_W'(1);

      for (int j = 0; j < PATTERN_MAX; j++) begin
         ext[j] = (CNT_W'(j) == win_cnt_ff) ? req_data_byte : win_ff[j];
      end

      // suffix starting at k still a prefix of the pattern?
      for (int k = 0; k <= PATTERN_MAX; k++) begin
         rem_k[k]  = total - LEN_W'(k);
         viable[k] = (LEN_W'(k) <= total) && (rem_k[k] <= eff_len);
         for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((k + i < PATTERN_MAX) && (LEN_W'(i) < rem_k[k]) &&
                (ext[(k + i) % PATTERN_MAX] != pat_bytes_ff[8*i +: 8])) begin
               viable[k] = 1'b0;
            end
         end
      end

      kpop = LEN_W'(PATTERN_MAX);
      for (int k = PATTERN_MAX; k >= 0; k--) begin
         if (viable[k]) begin
            kpop = LEN_W'(k);
         end
      end

      masked = (eff_len != '0) && ((total - kpop) == eff_len);

      for (int j = 0; j < PATTERN_MAX; j++) begin
         data_entry.bytes[j] = (LEN_W'(j) < kpop) ? ext[j] : MASK_CHAR;
         end_entry.bytes[j]  = win_ff[j];
      end
      data_entry.count  = masked ? total : kpop;
      data_entry.is_end = 1'b0;
      data_entry.empty  = 1'b0;

      end_entry.count  = (win_cnt_ff == '0) ? LEN_W'(1) : {1'b0, win_cnt_ff};
      end_entry.is_end = 1'b1;
      end_entry.empty  = (win_cnt_ff == '0);

      // shift the window past the released bytes
      for (int j = 0; j < PATTERN_MAX; j++) begin
         win_in[j] = ext[j];
         for (int s = 1; s < PATTERN_MAX; s++) begin
            if ((LEN_W'(s) == kpop) && (j + s < PATTERN_MAX)) begin
               win_in[j] = ext[(j + s) % PATTERN_MAX];
            end
         end
      end
      win_cnt_in = masked ? '0 : CNT_W'(total - kpop);

      if (req_kind == KIND_END) begin
         push_entry = end_entry;
         push       = accept;
      end else begin
         push_entry = data_entry;
         push       = accept && (data_entry.count != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= LEN_W'(1);
         pat_bytes_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_PATTERN_LENGTH: pat_len_ff   <= csr_wdata[LEN_W-1:0];
            REG_PATTERN_BYTES:  pat_bytes_ff <= csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cnt_ff <= '0;
      end else if (accept) begin
         win_cnt_ff <= (req_kind == KIND_END) ? '0 : win_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_kind == KIND_DATA) begin
         win_ff <= win_in;
      end
   end

endmodule

[design/smask_queue.sv]
// ----------------------------------------------------------------------------
// smask_queue
// Short FIFO of result entries between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smask_queue import smask_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  smask_entry_type push_entry,
   input  logic            pop,
   output smask_entry_type head,
   output smask_qstat_type q_stat
);

   smask_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;
   logic              do_push;
   logic              do_pop;

   assign q_stat.not_empty = (fill_ff != '0);
   assign q_stat.not_full  = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign do_push          = push && q_stat.not_full;
   assign do_pop           = pop && q_stat.not_empty;
   assign head             = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (do_push && !do_pop)      fill_ff <= fill_ff + QCNT_W'(1);
         else if (do_pop && !do_push) fill_ff <= fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/smask_back.sv]
// ----------------------------------------------------------------------------
// smask_back
// Walks the head entry, giving one result per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smask_back import smask_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  smask_entry_type head,
   input  smask_qstat_type q_stat,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_has_byte,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last_of_run,
   output logic            rsp_stream_end
);

   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             take;

   always_comb begin
      rsp_valid       = q_stat.not_empty;
      rsp_has_byte    = !head.empty;
      rsp_out_byte    = head.empty ? 8'h00 : head.bytes[idx_ff];
      rsp_last_of_run = ({1'b0, idx_ff} == (head.count - LEN_W'(1)));
      rsp_stream_end  = head.is_end;
      take            = rsp_valid && rsp_ready;
      pop             = take && rsp_last_of_run;
      idx_in          = idx_ff;
      if (take) begin
         idx_in = rsp_last_of_run ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[design/stream_pattern_mask_core.sv]
// ----------------------------------------------------------------------------
// stream_pattern_mask_core
// Copies a byte stream and replaces every leftmost, non-overlapping occurrence
// of a 1 to 8 byte pattern with asterisks. A request is taken in any cycle in
// which the four-entry result queue has room, so a new byte can enter every
// cycle; each request is turned into all of its results in that same cycle.
// A data request causes 0 to 8 results and an end-of-stream request 1 to 7;
// results leave through the single response port at one per cycle while
// rsp_ready is high. The first result of a request enters the queue when it
// is taken and shows once earlier entries have left. Pattern registers are to
// be written through the csr port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_pattern_mask_core import smask_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_stream_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   smask_qstat_type q_stat;
   smask_entry_type push_entry;
   smask_entry_type head;
   logic            push;
   logic            pop;

   smask_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .q_stat        (q_stat),
      .push          (push),
      .push_entry    (push_entry)
   );

   smask_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   smask_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_stream_end  (rsp_stream_end)
   );

endmodule

[design/smask_checker.sv]
// ----------------------------------------------------------------------------
// smask_checker
// Port-level checks on the stream pattern mask core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smask_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic [7:0]  req_data_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_has_byte,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last_of_run,
   input logic        rsp_stream_end,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [63:0] csr_wdata
);

   // nothing pending right after reset
   `SMASK_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)

   // a stalled response holds
   `SMASK_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))

   // results of one request come out without a gap
   `SMASK_ASSERT(a_run_contiguous, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)

   // an empty result only marks the end of an empty flush
   `SMASK_ASSERT(a_empty_is_end, clock, reset, rsp_valid && !rsp_has_byte |-> rsp_stream_end && rsp_last_of_run && rsp_out_byte == 8'h00)

endmodule

bind stream_pattern_mask_core smask_checker u_smask_checker (.*);
